// ===== hdl/wscrp_pkg.sv =====
// Shared types, constants and helper functions for the WebSocket client receive parser.
// No dependencies; every other file of the block uses this package by scoped names.
package wscrp_pkg;

  localparam int unsigned LengthBitsDefault = 64;
  localparam int unsigned FrameLenW = 64;
  localparam int unsigned StatusLen = 12;

  localparam logic [2:0] KindAccept  = 3'd0;
  localparam logic [2:0] KindReject  = 3'd1;
  localparam logic [2:0] KindMessage = 3'd2;
  localparam logic [2:0] KindPing    = 3'd3;
  localparam logic [2:0] KindClose   = 3'd4;
  localparam logic [2:0] ClassSkip   = 3'd7;

  localparam logic [3:0] OpContinue = 4'h0;
  localparam logic [3:0] OpText     = 4'h1;
  localparam logic [3:0] OpClose    = 4'h8;
  localparam logic [3:0] OpPing     = 4'h9;

  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  localparam logic CmdByte    = 1'b0;
  localparam logic CmdConnect = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [7:0]           payload_byte;
    logic                 last;
    logic                 empty_res;
    logic [FrameLenW-1:0] frame_length;
  } out_item_t;

  function automatic logic [7:0] status_char(logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h48;
      4'd1:    c = 8'h54;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h50;
      4'd4:    c = 8'h2F;
      4'd5:    c = 8'h31;
      4'd6:    c = 8'h2E;
      4'd7:    c = 8'h31;
      4'd8:    c = 8'h20;
      4'd9:    c = 8'h31;
      4'd10:   c = 8'h30;
      4'd11:   c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] frame_class(logic [3:0] opcode, logic fin);
    logic [2:0] cls;
    if (opcode == OpClose) begin
      cls = KindClose;
    end else if (opcode == OpPing) begin
      cls = KindPing;
    end else if ((opcode == OpText || opcode == OpContinue) && fin) begin
      cls = KindMessage;
    end else begin
      cls = ClassSkip;
    end
    return cls;
  endfunction

endpackage

// ===== hdl/wscrp_core.sv =====
// Parser state and single-pass next-state and result logic for one received byte.
// Depends on wscrp_pkg for item types, opcodes, result kinds and the status text.
module wscrp_core #(
  parameter int unsigned LENGTH_BITS = wscrp_pkg::LengthBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  wscrp_pkg::in_item_t  item_i,
  output logic                 res_valid_o,
  output wscrp_pkg::out_item_t res_o
);

  localparam logic [2:0] PhHandshake = 3'd0;
  localparam logic [2:0] PhHead0     = 3'd1;
  localparam logic [2:0] PhHead1     = 3'd2;
  localparam logic [2:0] PhExtLen    = 3'd3;
  localparam logic [2:0] PhMaskKey   = 3'd4;
  localparam logic [2:0] PhPayload   = 3'd5;
  localparam logic [2:0] PhStopped   = 3'd6;

  logic [2:0]             phase_q, phase_d;
  logic [1:0]             crlf_q, crlf_d;
  logic [3:0]             status_idx_q, status_idx_d;
  logic                   status_ok_q, status_ok_d;
  logic [3:0]             opcode_q, opcode_d;
  logic                   fin_q, fin_d;
  logic                   masked_q, masked_d;
  logic [2:0]             len_left_q, len_left_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic [3:0][7:0]        key_q, key_d;
  logic [1:0]             mask_idx_q, mask_idx_d;

  always_comb begin
    logic [7:0]             b;
    logic [7:0]             pb;
    logic [2:0]             cls;
    logic                   hdr_done;
    logic                   is_last;
    logic [LENGTH_BITS-1:0] count_inc;

    b = item_i.data_byte;
    cls = wscrp_pkg::frame_class(opcode_q, fin_q);
    hdr_done = 1'b0;
    pb = masked_q ? (b ^ key_q[mask_idx_q]) : b;
    count_inc = count_q + LENGTH_BITS'(1);
    is_last = (count_inc >= len_q);

    phase_d = phase_q;
    crlf_d = crlf_q;
    status_idx_d = status_idx_q;
    status_ok_d = status_ok_q;
    opcode_d = opcode_q;
    fin_d = fin_q;
    masked_d = masked_q;
    len_left_d = len_left_q;
    len_d = len_q;
    count_d = count_q;
    key_d = key_q;
    mask_idx_d = mask_idx_q;
    res_valid_o = 1'b0;
    res_o = '0;

    if (step_i) begin
      if (item_i.command == wscrp_pkg::CmdConnect) begin
        phase_d = PhHandshake;
        crlf_d = '0;
        status_idx_d = '0;
        status_ok_d = 1'b1;
        opcode_d = '0;
        fin_d = 1'b0;
        masked_d = 1'b0;
        len_left_d = '0;
        len_d = '0;
        count_d = '0;
        key_d = '0;
        mask_idx_d = '0;
      end else begin
        case (phase_q)
          PhHandshake: begin
            if (status_idx_q < 4'(wscrp_pkg::StatusLen)) begin
              if (b != wscrp_pkg::status_char(status_idx_q)) begin
                status_ok_d = 1'b0;
              end
              status_idx_d = status_idx_q + 4'd1;
            end
            if (b == wscrp_pkg::CharCr) begin
              crlf_d = (crlf_q == 2'd2) ? 2'd3 : 2'd1;
            end else if (b == wscrp_pkg::CharLf && crlf_q == 2'd1) begin
              crlf_d = 2'd2;
            end else if (b == wscrp_pkg::CharLf && crlf_q == 2'd3) begin
              crlf_d = '0;
              res_valid_o = 1'b1;
              res_o.last = 1'b1;
              if (status_ok_d && status_idx_d >= 4'(wscrp_pkg::StatusLen)) begin
                phase_d = PhHead0;
                res_o.kind = wscrp_pkg::KindAccept;
              end else begin
                phase_d = PhStopped;
                res_o.kind = wscrp_pkg::KindReject;
              end
            end else begin
              crlf_d = '0;
            end
          end
          PhHead0: begin
            opcode_d = b[3:0];
            fin_d = b[7];
            phase_d = PhHead1;
          end
          PhHead1: begin
            masked_d = b[7];
            len_d = '0;
            mask_idx_d = '0;
            if (b[6:0] == wscrp_pkg::Len16Code || b[6:0] == wscrp_pkg::Len64Code) begin
              len_left_d = (b[6:0] == wscrp_pkg::Len16Code) ? 3'd1 : 3'd7;
              phase_d = PhExtLen;
            end else begin
              len_d = LENGTH_BITS'(b[6:0]);
              if (b[7]) begin
                phase_d = PhMaskKey;
              end else begin
                hdr_done = 1'b1;
              end
            end
          end
          PhExtLen: begin
            if (|len_q[LENGTH_BITS-1 -: 8]) begin
              len_d = '1;
            end else begin
              len_d = {len_q[LENGTH_BITS-9:0], b};
            end
            if (len_left_q != 3'd0) begin
              len_left_d = len_left_q - 3'd1;
            end else if (masked_q) begin
              phase_d = PhMaskKey;
              mask_idx_d = '0;
            end else begin
              hdr_done = 1'b1;
            end
          end
          PhMaskKey: begin
            key_d[mask_idx_q] = b;
            mask_idx_d = mask_idx_q + 2'd1;
            if (mask_idx_d == 2'd0) begin
              hdr_done = 1'b1;
            end
          end
          PhPayload: begin
            mask_idx_d = mask_idx_q + 2'd1;
            count_d = is_last ? '0 : count_inc;
            if (is_last) begin
              phase_d = (cls == wscrp_pkg::KindClose) ? PhStopped : PhHead0;
            end
            if (cls == wscrp_pkg::KindClose) begin
              if (is_last) begin
                res_valid_o = 1'b1;
                res_o.kind = wscrp_pkg::KindClose;
                res_o.last = 1'b1;
                res_o.frame_length = wscrp_pkg::FrameLenW'(len_q);
              end
            end else if (cls != wscrp_pkg::ClassSkip) begin
              res_valid_o = 1'b1;
              res_o.kind = cls;
              res_o.payload_byte = pb;
              res_o.last = is_last;
              res_o.frame_length = wscrp_pkg::FrameLenW'(len_q);
            end
          end
          default: begin
          end
        endcase

        if (hdr_done) begin
          count_d = '0;
          mask_idx_d = '0;
          if (len_d != '0) begin
            phase_d = PhPayload;
          end else begin
            phase_d = (cls == wscrp_pkg::KindClose) ? PhStopped : PhHead0;
            if (cls != wscrp_pkg::ClassSkip) begin
              res_valid_o = 1'b1;
              res_o.kind = cls;
              res_o.last = 1'b1;
              res_o.empty_res = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHandshake;
      crlf_q <= '0;
      status_idx_q <= '0;
      status_ok_q <= 1'b1;
      opcode_q <= '0;
      fin_q <= 1'b0;
      masked_q <= 1'b0;
      len_left_q <= '0;
      len_q <= '0;
      count_q <= '0;
      key_q <= '0;
      mask_idx_q <= '0;
    end else begin
      phase_q <= phase_d;
      crlf_q <= crlf_d;
      status_idx_q <= status_idx_d;
      status_ok_q <= status_ok_d;
      opcode_q <= opcode_d;
      fin_q <= fin_d;
      masked_q <= masked_d;
      len_left_q <= len_left_d;
      len_q <= len_d;
      count_q <= count_d;
      key_q <= key_d;
      mask_idx_q <= mask_idx_d;
    end
  end

endmodule

// ===== hdl/websocket_client_receive_parser.sv =====
// WebSocket client receive parser, top level: input register, parser core, result register.
// Depends on wscrp_pkg and wscrp_core.
//
// The input channel (in_valid_i, in_ready_o, in_item_i) carries one transaction per
// received byte, or a connection-start command that returns the parser to the HTTP
// handshake phase without a result. The output channel (out_valid_o, out_ready_i,
// out_item_o) carries at most one result per input transaction: handshake accepted
// or rejected, an unmasked message or ping byte, or a close indication.
// An accepted transaction is held in the input register while the parser core
// updates its state; its result, if any, is then loaded into the result register.
// One transaction is taken per cycle while the receiver does not stall, limited
// only by the single pass through the core between the two registers. When the
// receiver stalls, the result register holds, the core stops, and the input
// register absorbs one more transaction before in_ready_o drops. Reset empties
// both registers and puts the parser in the handshake phase with all frame state
// cleared.
module websocket_client_receive_parser #(
  parameter int unsigned LENGTH_BITS = wscrp_pkg::LengthBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  wscrp_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wscrp_pkg::out_item_t out_item_o
);

  logic                 in_valid_q, in_valid_d;
  wscrp_pkg::in_item_t  in_item_q;
  logic                 out_valid_q, out_valid_d;
  wscrp_pkg::out_item_t out_item_q;
  logic                 advance;
  logic                 step;
  logic                 res_valid;
  wscrp_pkg::out_item_t res;

  assign advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step = in_valid_q && advance;
  assign in_valid_d = in_ready_o ? in_valid_i : in_valid_q;
  assign out_valid_d = advance ? (step && res_valid) : out_valid_q;

  wscrp_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
    if (step && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o = out_item_q;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && in_valid_q |=> in_valid_q)
    else $error("Input register advanced while the result register was stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind == wscrp_pkg::KindAccept ||
                    out_item_o.kind == wscrp_pkg::KindReject)
    |-> out_item_o.last && !out_item_o.empty_res && out_item_o.frame_length == '0)
    else $error("Handshake result carries frame fields.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.empty_res
    |-> out_item_o.last && out_item_o.payload_byte == 8'h00 &&
        out_item_o.frame_length == '0)
    else $error("Empty-frame result is malformed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && in_item_q.command == wscrp_pkg::CmdConnect |-> !res_valid)
    else $error("Connection start produced a result.");
`endif

endmodule
